FILE: hw/rtl/weighted_laplace_stencil_update_core_defines.svh
// Assertion macros shared by the stencil core RTL.
`ifndef WEIGHTED_LAPLACE_STENCIL_UPDATE_CORE_DEFINES_SVH
`define WEIGHTED_LAPLACE_STENCIL_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WLS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stencil core check failed");

// Next-cycle implication, checked out of reset.
`define WLS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stencil core check failed");

`endif

FILE: hw/rtl/wls_pkg.sv
package wls_pkg;

    localparam int VALUE_W  = 18;
    localparam int WEIGHT_W = 15;
    localparam int FLAG_W   = 4;
    localparam int CLASS_W  = 4;
    localparam int NB       = 4;    // neighbors: north, south, west, east

    // v*w is exact in this many bits for any 18-bit signed v and 15-bit w.
    localparam int PROD_W   = VALUE_W + WEIGHT_W;
    // Quotient magnitude never exceeds the largest value magnitude, 2^17.
    localparam int QUO_W    = VALUE_W;
    // Sum of gains is at most 6, so the weight sum fits 18 bits.
    localparam int DEN_W    = WEIGHT_W + 3;
    // Numerator magnitude is below 2^35; the divider takes QUO_W + DEN_W bits.
    localparam int NUM_W    = QUO_W + DEN_W;

    localparam int VALUE_MAX = 65536;
    localparam logic signed [QUO_W:0] SAT_HI = (QUO_W + 1)'(VALUE_MAX);
    localparam logic signed [QUO_W:0] SAT_LO = -SAT_HI;

    typedef enum logic [CLASS_W-1:0] {
        CLS_MIDDLE  = 4'd0,
        CLS_SIDE_N  = 4'd1,
        CLS_SIDE_S  = 4'd2,
        CLS_SIDE_W  = 4'd3,
        CLS_SIDE_E  = 4'd4,
        CLS_CRN_NE  = 4'd5,
        CLS_CRN_SE  = 4'd6,
        CLS_CRN_SW  = 4'd7,
        CLS_CRN_NW  = 4'd8,
        CLS_INV_NE  = 4'd9,
        CLS_INV_SE  = 4'd10,
        CLS_INV_SW  = 4'd11,
        CLS_INV_NW  = 4'd12,
        CLS_HELD    = 4'd13
    } stencil_class_t;

    // Flag patterns: edges bit0 N, bit1 S, bit2 W, bit3 E; diagonals bit0 NE .. bit3 NW.
    localparam logic [FLAG_W-1:0] EDGE_NONE = 4'h0;
    localparam logic [FLAG_W-1:0] EDGE_N    = 4'h1;
    localparam logic [FLAG_W-1:0] EDGE_S    = 4'h2;
    localparam logic [FLAG_W-1:0] EDGE_W    = 4'h4;
    localparam logic [FLAG_W-1:0] EDGE_E    = 4'h8;
    localparam logic [FLAG_W-1:0] EDGE_NE   = 4'h9;
    localparam logic [FLAG_W-1:0] EDGE_SE   = 4'hA;
    localparam logic [FLAG_W-1:0] EDGE_SW   = 4'h6;
    localparam logic [FLAG_W-1:0] EDGE_NW   = 4'h5;
    localparam logic [FLAG_W-1:0] DIAG_NE   = 4'h1;
    localparam logic [FLAG_W-1:0] DIAG_SE   = 4'h2;
    localparam logic [FLAG_W-1:0] DIAG_SW   = 4'h4;
    localparam logic [FLAG_W-1:0] DIAG_NW   = 4'h8;

    typedef logic [1:0] gain_t;
    localparam gain_t GAIN_ZERO = 2'd0;
    localparam gain_t GAIN_ONE  = 2'd1;
    localparam gain_t GAIN_TWO  = 2'd2;

    // Index 0 north, 1 south, 2 west, 3 east.
    typedef gain_t [NB-1:0] gain_vec_t;

    // Side band that travels with an item through the divider.
    typedef struct packed {
        logic [DEN_W-1:0]          den;
        logic                      neg;
        logic                      zero;
        stencil_class_t            cls;
        logic                      hold;
        logic signed [VALUE_W-1:0] cur;
    } div_side_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        stencil_class_t            cls;
    } result_t;

    function automatic stencil_class_t pick_class(input logic [FLAG_W-1:0] edges,
                                                  input logic [FLAG_W-1:0] diags);
        stencil_class_t cls;
        cls = CLS_MIDDLE;
        unique case (edges)
            EDGE_NONE: begin
                unique case (diags)
                    DIAG_NE: cls = CLS_INV_NE;
                    DIAG_SE: cls = CLS_INV_SE;
                    DIAG_SW: cls = CLS_INV_SW;
                    DIAG_NW: cls = CLS_INV_NW;
                    default: cls = CLS_MIDDLE;
                endcase
            end
            EDGE_N:  cls = CLS_SIDE_N;
            EDGE_S:  cls = CLS_SIDE_S;
            EDGE_W:  cls = CLS_SIDE_W;
            EDGE_E:  cls = CLS_SIDE_E;
            EDGE_NE: cls = CLS_CRN_NE;
            EDGE_SE: cls = CLS_CRN_SE;
            EDGE_SW: cls = CLS_CRN_SW;
            EDGE_NW: cls = CLS_CRN_NW;
            default: cls = CLS_MIDDLE;
        endcase
        return cls;
    endfunction

    function automatic gain_vec_t gains4(input gain_t n, input gain_t s,
                                         input gain_t w, input gain_t e);
        gain_vec_t g;
        g[0] = n;
        g[1] = s;
        g[2] = w;
        g[3] = e;
        return g;
    endfunction

    // Sides mirror a missing neighbor by doubling its opposite; corners drop both.
    function automatic gain_vec_t stencil_gain(input stencil_class_t cls);
        gain_vec_t g;
        unique case (cls)
            CLS_MIDDLE: g = gains4(GAIN_ONE,  GAIN_ONE,  GAIN_ONE,  GAIN_ONE);
            CLS_SIDE_N: g = gains4(GAIN_ZERO, GAIN_TWO,  GAIN_ONE,  GAIN_ONE);
            CLS_SIDE_S: g = gains4(GAIN_TWO,  GAIN_ZERO, GAIN_ONE,  GAIN_ONE);
            CLS_SIDE_W: g = gains4(GAIN_ONE,  GAIN_ONE,  GAIN_ZERO, GAIN_TWO);
            CLS_SIDE_E: g = gains4(GAIN_ONE,  GAIN_ONE,  GAIN_TWO,  GAIN_ZERO);
            CLS_CRN_NE: g = gains4(GAIN_ZERO, GAIN_ONE,  GAIN_ONE,  GAIN_ZERO);
            CLS_CRN_SE: g = gains4(GAIN_ONE,  GAIN_ZERO, GAIN_ONE,  GAIN_ZERO);
            CLS_CRN_SW: g = gains4(GAIN_ONE,  GAIN_ZERO, GAIN_ZERO, GAIN_ONE);
            CLS_CRN_NW: g = gains4(GAIN_ZERO, GAIN_ONE,  GAIN_ZERO, GAIN_ONE);
            CLS_INV_NE: g = gains4(GAIN_ONE,  GAIN_TWO,  GAIN_TWO,  GAIN_ONE);
            CLS_INV_SE: g = gains4(GAIN_TWO,  GAIN_ONE,  GAIN_TWO,  GAIN_ONE);
            CLS_INV_SW: g = gains4(GAIN_TWO,  GAIN_ONE,  GAIN_ONE,  GAIN_TWO);
            CLS_INV_NW: g = gains4(GAIN_ONE,  GAIN_TWO,  GAIN_ONE,  GAIN_TWO);
            default:    g = gains4(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
        endcase
        return g;
    endfunction

endpackage

FILE: hw/rtl/weighted_laplace_stencil_update_core.sv
// Pipeline: an accepted beat goes through multiply, weighted sums, sign split,
// 18 divider stages and the output register before m_valid rises.
// Throughput: one beat per clock while the skid stage is empty; the restoring
// divider retires one quotient bit per pipeline stage, 18 stages in all.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
`include "weighted_laplace_stencil_update_core_defines.svh"

module weighted_laplace_stencil_update_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [wls_pkg::VALUE_W-1:0]   s_north_value,
    input  logic signed [wls_pkg::VALUE_W-1:0]   s_south_value,
    input  logic signed [wls_pkg::VALUE_W-1:0]   s_west_value,
    input  logic signed [wls_pkg::VALUE_W-1:0]   s_east_value,
    input  logic        [wls_pkg::WEIGHT_W-1:0]  s_north_weight,
    input  logic        [wls_pkg::WEIGHT_W-1:0]  s_south_weight,
    input  logic        [wls_pkg::WEIGHT_W-1:0]  s_west_weight,
    input  logic        [wls_pkg::WEIGHT_W-1:0]  s_east_weight,
    input  logic        [wls_pkg::FLAG_W-1:0]    s_edge_open,
    input  logic        [wls_pkg::FLAG_W-1:0]    s_corner_open,
    input  logic                                 s_hold,
    input  logic signed [wls_pkg::VALUE_W-1:0]   s_current_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wls_pkg::VALUE_W-1:0]   m_new_value,
    output logic        [wls_pkg::CLASS_W-1:0]   m_stencil_class
);
    import wls_pkg::*;

    // The whole pipe advances together unless a result is parked in the skid stage.
    logic pipe_en;

    // ---------------- stage 1: products and stencil class ----------------
    logic signed [VALUE_W-1:0]  v_in [NB];
    logic        [WEIGHT_W-1:0] w_in [NB];
    logic signed [PROD_W-1:0]   s1_prod_next [NB];
    stencil_class_t             s1_cls_next;

    logic                       s1_vld_reg;
    logic signed [PROD_W-1:0]   s1_prod_reg [NB];
    logic        [WEIGHT_W-1:0] s1_w_reg [NB];
    stencil_class_t             s1_cls_reg;
    logic                       s1_hold_reg;
    logic signed [VALUE_W-1:0]  s1_cur_reg;

    assign v_in[0] = s_north_value;
    assign v_in[1] = s_south_value;
    assign v_in[2] = s_west_value;
    assign v_in[3] = s_east_value;
    assign w_in[0] = s_north_weight;
    assign w_in[1] = s_south_weight;
    assign w_in[2] = s_west_weight;
    assign w_in[3] = s_east_weight;

    always_comb begin
        logic signed [PROD_W:0] full;
        for (int k = 0; k < NB; k++) begin
            full = v_in[k] * $signed({1'b0, w_in[k]});
            s1_prod_next[k] = full[PROD_W-1:0];
        end
        s1_cls_next = s_hold ? CLS_HELD : pick_class(s_edge_open, s_corner_open);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_prod_reg <= s1_prod_next;
            s1_w_reg    <= w_in;
            s1_cls_reg  <= s1_cls_next;
            s1_hold_reg <= s_hold;
            s1_cur_reg  <= s_current_value;
        end
    end

    // ---------------- stage 2: weighted sums ----------------
    logic signed [NUM_W-1:0]  s2_num_next;
    logic        [DEN_W-1:0]  s2_den_next;

    logic                     s2_vld_reg;
    logic signed [NUM_W-1:0]  s2_num_reg;
    logic        [DEN_W-1:0]  s2_den_reg;
    stencil_class_t           s2_cls_reg;
    logic                     s2_hold_reg;
    logic signed [VALUE_W-1:0] s2_cur_reg;

    always_comb begin
        gain_vec_t               g;
        logic signed [NUM_W-1:0] pt;
        logic        [DEN_W-1:0] wt;
        g = stencil_gain(s1_cls_reg);
        s2_num_next = '0;
        s2_den_next = '0;
        for (int k = 0; k < NB; k++) begin
            pt = NUM_W'(s1_prod_reg[k]);
            wt = DEN_W'(s1_w_reg[k]);
            case (g[k])
                GAIN_ONE: begin
                end
                GAIN_TWO: begin
                    pt = pt <<< 1;
                    wt = wt << 1;
                end
                default: begin
                    pt = '0;
                    wt = '0;
                end
            endcase
            s2_num_next = s2_num_next + pt;
            s2_den_next = s2_den_next + wt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_num_reg  <= s2_num_next;
            s2_den_reg  <= s2_den_next;
            s2_cls_reg  <= s1_cls_reg;
            s2_hold_reg <= s1_hold_reg;
            s2_cur_reg  <= s1_cur_reg;
        end
    end

    // ---------------- stage 3 and divider: sign split, one bit a stage ----------------
    // Index 0 holds the split numerator; index j+1 holds the item after quotient bit j.
    logic             dv_vld_reg  [QUO_W+1];
    logic [DEN_W-1:0] dv_rem_reg  [QUO_W+1];
    logic [QUO_W-1:0] dv_low_reg  [QUO_W+1];
    logic [QUO_W-1:0] dv_quo_reg  [QUO_W+1];
    div_side_t        dv_side_reg [QUO_W+1];

    logic [NUM_W-1:0] s3_mag_next;
    div_side_t        s3_side_next;

    always_comb begin
        s3_mag_next       = s2_num_reg[NUM_W-1] ? NUM_W'(-s2_num_reg) : NUM_W'(s2_num_reg);
        s3_side_next.den  = s2_den_reg;
        s3_side_next.neg  = s2_num_reg[NUM_W-1];
        s3_side_next.zero = (s2_den_reg == '0);
        s3_side_next.cls  = s2_cls_reg;
        s3_side_next.hold = s2_hold_reg;
        s3_side_next.cur  = s2_cur_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            dv_vld_reg[0] <= s2_vld_reg;
        end
    end

    // Since the quotient stays below 2^QUO_W, the upper part starts below the divisor.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dv_rem_reg[0]  <= s3_mag_next[NUM_W-1:QUO_W];
            dv_low_reg[0]  <= s3_mag_next[QUO_W-1:0];
            dv_quo_reg[0]  <= '0;
            dv_side_reg[0] <= s3_side_next;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb begin
            trial = {dv_rem_reg[j], dv_low_reg[j][QUO_W-1]};
            diff  = trial - {1'b0, dv_side_reg[j].den};
            if (trial >= {1'b0, dv_side_reg[j].den}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {dv_quo_reg[j][QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {dv_quo_reg[j][QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j+1] <= 1'b0;
            end else if (pipe_en) begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                dv_rem_reg[j+1]  <= rem_next;
                dv_low_reg[j+1]  <= dv_low_reg[j] << 1;
                dv_quo_reg[j+1]  <= quo_next;
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // ---------------- result: sign, saturation, zero divisor, hold, output and skid ----------------
    logic                  fin_vld;
    result_t               fin_res;
    logic signed [QUO_W:0] fin_sq;
    logic signed [QUO_W:0] fin_sat;

    assign fin_vld = dv_vld_reg[QUO_W];

    always_comb begin
        fin_sq = dv_side_reg[QUO_W].neg ? -$signed({1'b0, dv_quo_reg[QUO_W]})
                                        :  $signed({1'b0, dv_quo_reg[QUO_W]});
        if (fin_sq > SAT_HI) begin
            fin_sat = SAT_HI;
        end else if (fin_sq < SAT_LO) begin
            fin_sat = SAT_LO;
        end else begin
            fin_sat = fin_sq;
        end
        fin_res.cls = dv_side_reg[QUO_W].cls;
        if (dv_side_reg[QUO_W].hold) begin
            fin_res.value = dv_side_reg[QUO_W].cur;
        end else if (dv_side_reg[QUO_W].zero) begin
            fin_res.value = '0;
        end else begin
            fin_res.value = fin_sat[VALUE_W-1:0];
        end
    end

    logic    out_vld_reg,  out_vld_next;
    logic    skid_vld_reg, skid_vld_next;
    result_t out_res_reg,  out_res_next;
    result_t skid_res_reg, skid_res_next;

    assign pipe_en = !skid_vld_reg;
    assign s_ready = pipe_en;

    always_comb begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_res_next  = out_res_reg;
        skid_res_next = skid_res_reg;
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_res_next  = skid_res_reg;
                skid_vld_next = 1'b0;
            end
        end else if (fin_vld) begin
            if (!out_vld_reg || m_ready) begin
                out_res_next = fin_res;
                out_vld_next = 1'b1;
            end else begin
                skid_res_next = fin_res;
                skid_vld_next = 1'b1;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_valid         = out_vld_reg;
    assign m_new_value     = out_res_reg.value;
    assign m_stencil_class = out_res_reg.cls;

    // ---------------- checks ----------------
    `WLS_ASSERT_NEXT(a_accept_enters_pipe, aclk, aresetn, s_valid && s_ready, s1_vld_reg)
    `WLS_ASSERT_IMPL(a_skid_behind_output, aclk, aresetn, skid_vld_reg, out_vld_reg)
    `WLS_ASSERT_NEXT(a_stall_freezes_pipe, aclk, aresetn, skid_vld_reg, $stable(fin_vld))
    `WLS_ASSERT_IMPL(a_rem_below_divisor, aclk, aresetn, fin_vld && !dv_side_reg[QUO_W].zero, dv_rem_reg[QUO_W] < dv_side_reg[QUO_W].den)

endmodule
